### sv/sseex_pkg.sv
// Shared types, constants and helpers for the event-stream data extractor.
package sseex_pkg;

  localparam int LIMIT_W         = 25;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd1048576;

  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // Line position codes: prefix bytes matched, then data-line content modes.
  localparam logic [2:0] POS_START   = 3'd0;
  localparam logic [2:0] POS_COLON   = 3'd5;
  localparam logic [2:0] POS_SPACED  = 3'd6;
  localparam logic [2:0] POS_NOSPACE = 3'd7;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CLS_UNDEC = 3'b001,
    CLS_DATA  = 3'b010,
    CLS_OTHER = 3'b100
  } cls_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  // Results caused by one input: one or two.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Expected byte of the "data:" prefix at a given position.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h64;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/sseex_front.sv
// Front end: line/prefix parser, size check and limit register.
module sseex_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic                          op,
  input  logic [7:0]                    in_data,
  input  logic                          cfg_we,
  input  logic [sseex_pkg::LIMIT_W-1:0] cfg_data,
  output logic                          grp_valid,
  output sseex_pkg::grp_t               grp,
  output logic                          failed
);
  import sseex_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [2:0]         pos_r, pos_nxt;
  cls_t               cls_r, cls_nxt;
  logic               cr_r, cr_nxt;
  logic               open_r, open_nxt;
  logic [LIMIT_W-1:0] count_r, count_nxt;
  logic [LIMIT_W-1:0] lbytes_r, lbytes_nxt;
  logic               failed_r, failed_nxt;

  res_t               res_v [2];
  logic [1:0]         n_v;
  logic [LIMIT_W-1:0] dm1;

  always_comb begin
    pos_nxt    = pos_r;
    cls_nxt    = cls_r;
    cr_nxt     = cr_r;
    open_nxt   = open_r;
    count_nxt  = count_r;
    lbytes_nxt = lbytes_r;
    failed_nxt = failed_r;
    res_v[0]   = '0;
    res_v[1]   = '0;
    n_v        = 2'd0;
    dm1        = '0;

    if (!failed_r) begin
      if (op == OP_FINISH) begin
        if (open_r) begin
          res_v[n_v[0]] = '{kind: KIND_END, data: 8'h00};
          n_v = n_v + 2'd1;
        end
        open_nxt   = 1'b0;
        count_nxt  = '0;
        pos_nxt    = POS_START;
        cls_nxt    = CLS_UNDEC;
        cr_nxt     = 1'b0;
        lbytes_nxt = '0;
      end else if (count_r >= limit_r) begin
        failed_nxt = 1'b1;
        res_v[n_v[0]] = '{kind: KIND_ERROR, data: 8'h00};
        n_v = n_v + 2'd1;
      end else if (in_data == BYTE_LF) begin
        // count+1-drop, written as count-(drop-1) and floored at zero
        if (cls_r == CLS_UNDEC && pos_r == POS_START) begin
          if (open_r) begin
            res_v[n_v[0]] = '{kind: KIND_END, data: 8'h00};
            n_v = n_v + 2'd1;
          end
          open_nxt  = 1'b0;
          count_nxt = '0;
        end else begin
          if (cls_r == CLS_DATA) begin
            dm1 = ((pos_r == POS_SPACED) ? LIMIT_W'(5) : LIMIT_W'(4)) + LIMIT_W'(cr_r);
          end else begin
            dm1 = lbytes_r;
          end
          count_nxt = (count_r >= dm1) ? count_r - dm1 : '0;
        end
        pos_nxt    = POS_START;
        cls_nxt    = CLS_UNDEC;
        cr_nxt     = 1'b0;
        lbytes_nxt = '0;
      end else begin
        count_nxt  = count_r + LIMIT_W'(1);
        lbytes_nxt = lbytes_r + LIMIT_W'(1);
        // held CR not followed by LF is a plain line byte
        if (cr_r) begin
          cr_nxt = 1'b0;
          if (cls_nxt == CLS_DATA) begin
            res_v[n_v[0]] = '{kind: KIND_PAYLOAD, data: BYTE_CR};
            n_v = n_v + 2'd1;
          end else begin
            cls_nxt = CLS_OTHER;
          end
        end
        if (cls_nxt == CLS_UNDEC) begin
          if (pos_r < POS_COLON && in_data == prefix_char(pos_r)) begin
            pos_nxt = pos_r + 3'd1;
            if (pos_nxt == POS_COLON) begin
              cls_nxt = CLS_DATA;
              if (open_r) begin
                res_v[n_v[0]] = '{kind: KIND_PAYLOAD, data: BYTE_LF};
                n_v = n_v + 2'd1;
              end
              open_nxt = 1'b1;
            end
          end else if (in_data == BYTE_CR && pos_r == POS_START) begin
            cr_nxt = 1'b1;
          end else begin
            cls_nxt = CLS_OTHER;
          end
        end else if (cls_nxt == CLS_DATA) begin
          if (pos_r == POS_COLON && in_data == BYTE_SPACE) begin
            pos_nxt = POS_SPACED;
          end else begin
            if (pos_r == POS_COLON) begin
              pos_nxt = POS_NOSPACE;
            end
            if (in_data == BYTE_CR) begin
              cr_nxt = 1'b1;
            end else begin
              res_v[n_v[0]] = '{kind: KIND_PAYLOAD, data: in_data};
              n_v = n_v + 2'd1;
            end
          end
        end
      end
    end
  end

  assign grp_valid = acc && (n_v != 2'd0);
  assign grp.two   = n_v[1];
  assign grp.r0    = res_v[0];
  assign grp.r1    = res_v[1];
  assign failed    = failed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      pos_r    <= POS_START;
      cls_r    <= CLS_UNDEC;
      cr_r     <= 1'b0;
      open_r   <= 1'b0;
      count_r  <= '0;
      lbytes_r <= '0;
      failed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (acc) begin
        pos_r    <= pos_nxt;
        cls_r    <= cls_nxt;
        cr_r     <= cr_nxt;
        open_r   <= open_nxt;
        count_r  <= count_nxt;
        lbytes_r <= lbytes_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

endmodule

### sv/sseex_queue.sv
// Result-group queue between the parser and the output serializer.
module sseex_queue #(
  parameter int DEPTH = sseex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  sseex_pkg::grp_t   wr_grp,
  input  logic              rd,
  output sseex_pkg::grp_t   head,
  output sseex_pkg::qstat_t stat
);
  import sseex_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (rd) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr_r] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign head       = mem[rptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### sv/sseex_back.sv
// Back end: serializes queued result groups into single result transfers.
module sseex_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sseex_pkg::grp_t   head,
  input  logic              q_empty,
  input  logic              pop,
  output logic              q_rd,
  output logic [1:0]        kind,
  output logic [7:0]        data,
  output logic              last
);
  import sseex_pkg::*;

  logic sub_r, sub_nxt;
  res_t cur;
  logic xfer;

  assign xfer = pop && !q_empty;
  assign last = !head.two || sub_r;
  assign cur  = (head.two && !sub_r) ? head.r0 : (sub_r ? head.r1 : head.r0);
  assign kind = cur.kind;
  assign data = cur.data;
  assign q_rd = xfer && last;

  always_comb begin
    sub_nxt = sub_r;
    if (xfer) begin
      sub_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

### sv/sse_event_data_extractor_unit.sv
// Top level of the event-stream data extractor.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------
//   input    | in        | push / full        | in_op, in_byte
//   result   | out       | empty / pop        | out_kind, out_byte, out_last
//   config   | in        | cfg_valid/cfg_ready| cfg_data (size limit)
//
// One input transfer per clock while full is low; the parser updates its
// line and size state in the cycle of the transfer, so there is no stall
// between consecutive bytes. The result side moves one result per clock
// while pop is high, so an input that causes two results takes two
// transfers; the group queue (QUEUE_DEPTH entries) absorbs that and any pop
// stalls, and full rises only when it is out of entries. Results reach the
// output ports from the registered group queue.
// Reset is synchronous, active low; it restores the 1 MiB size limit and
// clears parser state, the sticky error and the queue.
module sse_event_data_extractor_unit #(
  parameter int QUEUE_DEPTH = sseex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  logic                          in_op,
  input  logic [7:0]                    in_byte,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sseex_pkg::LIMIT_W-1:0] cfg_data
);
  import sseex_pkg::*;

  logic   acc;
  logic   grp_valid;
  grp_t   grp;
  logic   failed;
  grp_t   head;
  qstat_t qstat;
  logic   q_rd;

  // limit register is always writable
  assign cfg_ready = 1'b1;

  assign acc   = push && !qstat.full;
  assign full  = qstat.full;
  assign empty = qstat.empty;

  sseex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .op        (in_op),
    .in_data   (in_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .grp_valid (grp_valid),
    .grp       (grp),
    .failed    (failed)
  );

  sseex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (grp_valid),
    .wr_grp (grp),
    .rd     (q_rd),
    .head   (head),
    .stat   (qstat)
  );

  sseex_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (qstat.empty),
    .pop     (pop),
    .q_rd    (q_rd),
    .kind    (out_kind),
    .data    (out_byte),
    .last    (out_last)
  );

  // Event end and overflow error are always the final result of their input.
  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_PAYLOAD) |-> out_last)
    else $error("non-payload result without last");

  // The overflow error is sticky: nothing enters the queue afterwards.
  a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    failed |-> !grp_valid)
    else $error("result produced after overflow");

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed |=> failed)
    else $error("overflow flag cleared without reset");

  // Queue writes only come from accepted input transfers.
  a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid |-> (push && !full))
    else $error("queue write without input transfer");

endmodule
